// ===== rtl/tdp_pkg.sv =====
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types and constants for the trial-division prime tester.
// ----------------------------------------------------------------------------
package tdp_pkg;

	// default width of the tested value
	localparam int VALUE_BITS_DEF = 31;

	// first trial divisor; values below it are never prime
	localparam int FIRST_DIVISOR = 2;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_WAIT,
		ST_FINISH
	} tdp_state_t;

	// status from the serial divider
	typedef struct packed {
		logic done;
		logic rem_zero;
	} tdp_div_stat_t;

endpackage

// ===== rtl/tdp_if.sv =====
// ----------------------------------------------------------------------------
// tdp_req_if / tdp_rsp_if
// Valid/ready channels carrying the candidate word and the verdict word.
// ----------------------------------------------------------------------------
interface tdp_req_if #(
	parameter int VALUE_BITS = 31
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_rsp_if #(
	parameter int VALUE_BITS = 31
);
	logic                  valid;
	logic                  ready;
	logic                  is_prime;
	logic [VALUE_BITS-1:0] tested_value;

	modport source (output valid, output is_prime, output tested_value, input ready);
	modport sink   (input valid, input is_prime, input tested_value, output ready);
endinterface

// ===== rtl/trial_division_prime_test_top.sv =====
// Time to a result grows with the number of trial divisors tried; values below two
// skip the divider and go to the output register without any division.
// Each divisor costs one serial division at one quotient bit per cycle, so a
// 31-bit prime needs about 46340 divisors.
// One word in flight; the next word is taken once its result sits in the output register.
// Reset clears the sequencer and the output valid flag; no memories.
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Decides primality of each candidate by trial division with a serial divider.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top import tdp_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	tdp_req_if.sink   req,
	tdp_rsp_if.source rsp
);

	tdp_state_t            state_q, state_d;
	logic [VALUE_BITS-1:0] n_q;
	logic [VALUE_BITS-1:0] d_q;
	logic                  prime_q;
	logic                  out_valid_q;
	logic                  out_prime_q;
	logic [VALUE_BITS-1:0] out_value_q;

	logic                  start;
	logic                  accept;
	logic                  adv;
	logic                  verdict_set;
	logic                  verdict;
	logic                  load_out;
	tdp_div_stat_t         div_stat;
	logic [VALUE_BITS-1:0] div_quo;

	tdp_serial_div #(.VALUE_BITS(VALUE_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (n_q),
		.divisor  (d_q),
		.stat     (div_stat),
		.quo      (div_quo)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && (state_q == ST_IDLE);

	// next state and sequencer strobes
	always_comb begin
		state_d     = state_q;
		start       = 1'b0;
		adv         = 1'b0;
		verdict_set = 1'b0;
		verdict     = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (req.candidate < VALUE_BITS'(FIRST_DIVISOR)) begin
						verdict_set = 1'b1;
						state_d     = ST_FINISH;
					end else begin
						state_d = ST_LAUNCH;
					end
				end
			end
			ST_LAUNCH: begin
				start   = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_stat.done) begin
					if (d_q > div_quo) begin
						// divisor passed the square root: no factor exists
						verdict_set = 1'b1;
						verdict     = 1'b1;
						state_d     = ST_FINISH;
					end else if (div_stat.rem_zero) begin
						verdict_set = 1'b1;
						state_d     = ST_FINISH;
					end else begin
						adv     = 1'b1;
						state_d = ST_LAUNCH;
					end
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture candidate, advance divisor, record verdict, load output word
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= req.candidate;
			d_q <= VALUE_BITS'(FIRST_DIVISOR);
		end else if (adv) begin
			d_q <= d_q + VALUE_BITS'(1);
		end
		if (verdict_set) begin
			prime_q <= verdict;
		end
		if (load_out) begin
			out_prime_q <= prime_q;
			out_value_q <= n_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.is_prime     = out_prime_q;
	assign rsp.tested_value = out_value_q;

endmodule

// ===== rtl/tdp_serial_div.sv =====
// ----------------------------------------------------------------------------
// tdp_serial_div
// Restoring divider that produces one quotient bit per cycle. The dividend
// shifts out of a register MSB first while the quotient shifts in.
// ----------------------------------------------------------------------------
module tdp_serial_div import tdp_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output tdp_div_stat_t         stat,
	output logic [VALUE_BITS-1:0] quo
);

	localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] shift_q;
	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS:0]   diff;
	logic                  fits;

	// one restoring step: bring down the next dividend bit, try a subtract
	always_comb begin
		trial = {rem_q, shift_q[VALUE_BITS-1]};
		diff  = trial - {1'b0, divisor};
		fits  = (trial >= {1'b0, divisor});
	end

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: partial remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			shift_q <= dividend;
		end else if (busy_q) begin
			rem_q   <= fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
			shift_q <= {shift_q[VALUE_BITS-2:0], fits};
		end
	end

	assign stat.done     = done_q;
	assign stat.rem_zero = (rem_q == '0);
	assign quo           = shift_q;

endmodule

// ===== rtl/tdp_checker.sv =====
// ----------------------------------------------------------------------------
// tdp_checker
// Port-level checks on the prime tester, bound to the top level.
// ----------------------------------------------------------------------------
module tdp_checker import tdp_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic                  is_prime,
	input logic [VALUE_BITS-1:0] tested_value
);

	// stalled result word stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result valid dropped while stalled");

	// stalled result payload holds
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(tested_value) && $stable(is_prime))
		else $error("result payload changed while stalled");

	// zero and one never reported prime
	a_small: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_prime |-> tested_value >= VALUE_BITS'(FIRST_DIVISOR))
		else $error("value below two reported prime");

	// even values other than two are composite
	a_even: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !tested_value[0] && tested_value != VALUE_BITS'(FIRST_DIVISOR)
		|-> !is_prime)
		else $error("even value reported prime");

endmodule

bind trial_division_prime_test_top tdp_checker #(.VALUE_BITS(VALUE_BITS)) u_tdp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.is_prime     (rsp.is_prime),
	.tested_value (rsp.tested_value)
);
